// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; msht_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/msht_pkg.sv -----
`timescale 1ns / 1ps

package msht_pkg;

    localparam int ENTRIES  = 16;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W   = 64;
    localparam int KIND_W   = 2;
    localparam int OCC_W    = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;

    typedef enum logic [2:0] {
        STAT_STORED,
        STAT_PASSED,
        STAT_HELD,
        STAT_DROPPED,
        STAT_DEL_HIT,
        STAT_DEL_MISS,
        STAT_REMAP_HIT,
        STAT_REMAP_MISS
    } status_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_REMAP
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [ADDR_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
        logic              released;
        logic [ADDR_W-1:0] released_address;
        logic              released_writeback;
    } result_t;

endpackage

// ----- rtl/miss_status_table_unit.sv -----
`timescale 1ns / 1ps

// Ordered table of outstanding miss addresses with one hold slot. Every
// transaction gives exactly one result. All work runs through a single 64-bit
// address comparator and one table port with a registered read, one entry per
// cycle: a remap scans the table up to its match; a delete scans to the match,
// then pulls each younger entry down one slot. The input stalls from acceptance
// until the result is registered; a finished result may wait at the output
// while the next transaction is already taken. No clearing pass follows reset.
module miss_status_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [msht_pkg::KIND_W-1:0]       kind,
    input  logic [msht_pkg::ADDR_W-1:0]       address,
    input  logic [msht_pkg::ADDR_W-1:0]       new_address,
    input  logic                              is_writeback,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [msht_pkg::OCC_W-1:0]        occupancy,
    output logic                              released,
    output logic [msht_pkg::ADDR_W-1:0]       released_address,
    output logic                              released_writeback
);

    msht_pkg::mem_req_t          mem_req;
    logic [msht_pkg::ADDR_W-1:0] rd_data;
    logic                        busy;
    logic                        out_free;
    logic                        res_valid;
    msht_pkg::result_t           result;
    logic                        out_valid_reg, out_valid_next;
    msht_pkg::result_t           result_reg;

    msht_table u_table (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    msht_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .kind         (kind),
        .address      (address),
        .new_address  (new_address),
        .is_writeback (is_writeback),
        .busy         (busy),
        .rd_data      (rd_data),
        .mem_req      (mem_req),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .result       (result)
    );

    // output register frees up when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = busy;

    always_comb
    begin
        if (res_valid && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            result_reg <= result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = result_reg.status;
    assign occupancy          = result_reg.occupancy;
    assign released           = result_reg.released;
    assign released_address   = result_reg.released_address;
    assign released_writeback = result_reg.released_writeback;

endmodule

// ----- rtl/msht_table.sv -----
`timescale 1ns / 1ps

module msht_table (
    input  logic                         clk,
    input  msht_pkg::mem_req_t           req,
    output logic [msht_pkg::ADDR_W-1:0]  rd_data
);

    logic [msht_pkg::ADDR_W-1:0] mem [msht_pkg::ENTRIES];
    logic [msht_pkg::ADDR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/msht_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msht_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [msht_pkg::KIND_W-1:0]       kind,
    input  logic [msht_pkg::ADDR_W-1:0]       address,
    input  logic [msht_pkg::ADDR_W-1:0]       new_address,
    input  logic                              is_writeback,
    output logic                              busy,
    input  logic [msht_pkg::ADDR_W-1:0]       rd_data,
    output msht_pkg::mem_req_t                mem_req,
    input  logic                              out_free,
    output logic                              res_valid,
    output msht_pkg::result_t                 result
);

    msht_pkg::state_t state_reg, state_next;
    msht_pkg::op_t    op_reg, op_next, in_op;

    logic [msht_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [msht_pkg::ADDR_W-1:0] naddr_reg, naddr_next;
    logic                        wb_reg, wb_next;
    logic                        hit_reg, hit_next;
    logic [msht_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [msht_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        hold_valid_reg, hold_valid_next;
    logic [msht_pkg::ADDR_W-1:0] hold_addr_reg, hold_addr_next;
    logic                        hold_wb_reg, hold_wb_next;

    logic                        in_take;
    logic                        match;
    logic                        idx_more;
    logic                        finish_load;
    logic                        full;
    logic                        cand_en;
    logic [msht_pkg::ADDR_W-1:0] cand_addr;
    logic                        cand_wb;
    logic                        cand_hold;
    logic                        cand_pass;
    logic                        cand_store;
    logic [msht_pkg::CNT_W-1:0]  count_final;

    assign in_take     = in_valid && (state_reg == msht_pkg::ST_IDLE);
    // the one shared comparator: table word under scan against the key
    assign match       = (rd_data == addr_reg);
    assign idx_more    = (msht_pkg::CNT_W'(idx_reg + 1'b1) < count_reg);
    assign finish_load = (state_reg == msht_pkg::ST_FINISH) && out_free;
    assign full        = (count_reg >= msht_pkg::CNT_W'(msht_pkg::ENTRIES));

    always_comb
    begin
        case (kind)
            msht_pkg::KIND_INSERT: in_op = msht_pkg::OP_INSERT;
            msht_pkg::KIND_DELETE: in_op = msht_pkg::OP_DELETE;
            default:               in_op = msht_pkg::OP_REMAP;
        endcase
    end

    // insert path, shared by a new insert and by a release from the hold slot
    assign cand_en    = ((op_reg == msht_pkg::OP_INSERT) && !hold_valid_reg)
                     || ((op_reg == msht_pkg::OP_DELETE) && hold_valid_reg);
    assign cand_addr  = (op_reg == msht_pkg::OP_INSERT) ? addr_reg : hold_addr_reg;
    assign cand_wb    = (op_reg == msht_pkg::OP_INSERT) ? wb_reg : hold_wb_reg;
    assign cand_hold  = cand_en && full;
    assign cand_pass  = cand_en && !full && cand_wb;
    assign cand_store = cand_en && !full && !cand_wb;
    assign count_final = count_reg + msht_pkg::CNT_W'(cand_store);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msht_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_op == msht_pkg::OP_INSERT || count_reg == '0)
                    begin
                        state_next = msht_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = msht_pkg::ST_SCAN;
                    end
                end
            end
            msht_pkg::ST_SCAN:
            begin
                if (match && op_reg == msht_pkg::OP_DELETE)
                begin
                    state_next = msht_pkg::ST_SHIFT;
                end
                else if (match || !idx_more)
                begin
                    state_next = msht_pkg::ST_FINISH;
                end
            end
            msht_pkg::ST_SHIFT:
            begin
                if (!idx_more)
                begin
                    state_next = msht_pkg::ST_FINISH;
                end
            end
            msht_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = msht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msht_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: handshake, table port, result
    always_comb
    begin
        busy          = (state_reg != msht_pkg::ST_IDLE);
        res_valid     = (state_reg == msht_pkg::ST_FINISH);
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[msht_pkg::IDX_W-1:0];
        mem_req.wdata = rd_data;
        mem_req.raddr = '0;
        case (state_reg)
            msht_pkg::ST_IDLE:
            begin
                mem_req.raddr = '0;
            end
            msht_pkg::ST_SCAN:
            begin
                mem_req.raddr = msht_pkg::IDX_W'(idx_reg + 1'b1);
                if (match && op_reg == msht_pkg::OP_REMAP)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = naddr_reg;
                end
            end
            msht_pkg::ST_SHIFT:
            begin
                // pull the younger neighbor down one slot
                mem_req.raddr = msht_pkg::IDX_W'(idx_reg + 2'd2);
                mem_req.we    = idx_more;
            end
            msht_pkg::ST_FINISH:
            begin
                mem_req.we    = finish_load && cand_store;
                mem_req.waddr = count_reg[msht_pkg::IDX_W-1:0];
                mem_req.wdata = cand_addr;
            end
            default:
            begin
                mem_req.we = 1'b0;
            end
        endcase

        case (op_reg)
            msht_pkg::OP_INSERT:
            begin
                if (hold_valid_reg)
                begin
                    result.status = msht_pkg::STAT_DROPPED;
                end
                else if (cand_hold)
                begin
                    result.status = msht_pkg::STAT_HELD;
                end
                else if (cand_pass)
                begin
                    result.status = msht_pkg::STAT_PASSED;
                end
                else
                begin
                    result.status = msht_pkg::STAT_STORED;
                end
            end
            msht_pkg::OP_DELETE:
            begin
                result.status = hit_reg ? msht_pkg::STAT_DEL_HIT : msht_pkg::STAT_DEL_MISS;
            end
            default:
            begin
                result.status = hit_reg ? msht_pkg::STAT_REMAP_HIT : msht_pkg::STAT_REMAP_MISS;
            end
        endcase
        result.occupancy          = msht_pkg::OCC_W'(count_final);
        result.released           = (op_reg == msht_pkg::OP_DELETE) && (cand_pass || cand_store);
        result.released_address   = result.released ? hold_addr_reg : '0;
        result.released_writeback = (op_reg == msht_pkg::OP_DELETE) && cand_pass;
    end

    // datapath next values
    always_comb
    begin
        op_next         = op_reg;
        addr_next       = addr_reg;
        naddr_next      = naddr_reg;
        wb_next         = wb_reg;
        hit_next        = hit_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        hold_valid_next = hold_valid_reg;
        hold_addr_next  = hold_addr_reg;
        hold_wb_next    = hold_wb_reg;
        case (state_reg)
            msht_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = in_op;
                    addr_next  = address;
                    naddr_next = new_address;
                    wb_next    = is_writeback;
                    hit_next   = 1'b0;
                    idx_next   = '0;
                end
            end
            msht_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    hit_next = 1'b1;
                end
                else if (idx_more)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            msht_pkg::ST_SHIFT:
            begin
                if (idx_more)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            msht_pkg::ST_FINISH:
            begin
                if (finish_load)
                begin
                    count_next = count_final;
                    if (cand_en)
                    begin
                        hold_valid_next = cand_hold;
                        hold_addr_next  = cand_hold ? cand_addr : '0;
                        hold_wb_next    = cand_hold && cand_wb;
                    end
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= msht_pkg::ST_IDLE;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            hold_addr_reg  <= '0;
            hold_wb_reg    <= 1'b0;
            op_reg         <= msht_pkg::OP_INSERT;
            hit_reg        <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            hold_addr_reg  <= hold_addr_next;
            hold_wb_reg    <= hold_wb_next;
            op_reg         <= op_next;
            hit_reg        <= hit_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        naddr_reg <= naddr_next;
        wb_reg    <= wb_next;
    end

    `ASSERT_HOLDS(a_count_bound, clk, rst_n, count_reg <= msht_pkg::CNT_W'(msht_pkg::ENTRIES), "table count above capacity")
    `ASSERT_IMPLIES(a_hold_only_full, clk, rst_n, hold_valid_reg && state_reg == msht_pkg::ST_IDLE, full, "hold slot busy while table has room")
    `ASSERT_IMPLIES(a_scan_in_range, clk, rst_n, state_reg == msht_pkg::ST_SCAN || state_reg == msht_pkg::ST_SHIFT, idx_reg < count_reg, "scan index past table tail")
    `ASSERT_NEXT(a_remap_keeps_count, clk, rst_n, state_reg != msht_pkg::ST_IDLE && op_reg == msht_pkg::OP_REMAP, count_reg == $past(count_reg), "remap changed table count")

endmodule
